// ===== sv/lprg_pkg.sv =====
// ----------------------------------------------------------------------------
// lprg_pkg: shared types and constants for the lidar point range gate
// Coordinate width, beat layouts, register codes and the divide-by-1000
// reciprocal used for nanosecond to microsecond conversion.
// ----------------------------------------------------------------------------
package lprg_pkg;

  localparam int COORD_WIDTH = 24;

  // squared magnitude of one axis and the sum of three of them
  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int D2_W = SQ_W + 2;

  localparam int FMT_W      = 2;
  localparam int DECIM_W    = 6;
  localparam int RANGE_W    = 20;
  localparam int BOUND_SQ_W = 2 * RANGE_W;
  localparam int CMP_W      = (D2_W > BOUND_SQ_W) ? D2_W : BOUND_SQ_W;

  localparam int LINE_W  = 8;
  localparam int TAG_W   = 8;
  localparam int INTEN_W = 16;
  localparam int TIME_W  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RANGE_W;

  // beat layouts, first field in the lowest bits, padded to whole bytes
  localparam int IN_BITS     = 3 * COORD_WIDTH + LINE_W + TAG_W + INTEN_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * COORD_WIDTH + INTEN_W + TIME_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // lines at or above this are dropped in the line-tagged format
  localparam logic [LINE_W-1:0] LINE_LIMIT = 8'd4;
  // tag bits 5:4 of 2 or 3 drop the point, i.e. bit 5 set
  localparam int TAG_DROP_BIT = 5;

  // floor(t / 1000) == (t * DIV1000_MUL) >> DIV1000_SHIFT for every 32-bit t
  localparam logic [TIME_W-1:0] DIV1000_MUL   = 32'h8312_6E98;
  localparam int                DIV1000_SHIFT = 41;
  localparam int                PROD_W        = 2 * TIME_W;

  localparam logic [DECIM_W-1:0]    DECIM_RESET  = 6'd1;
  localparam logic [BOUND_SQ_W-1:0] MIN_SQ_RESET = '0;
  // 100000 mm squared
  localparam logic [BOUND_SQ_W-1:0] MAX_SQ_RESET = 40'd10000000000;

  typedef enum logic [FMT_W-1:0] {
    FMT_LINE_NS = 2'd0,
    FMT_NS      = 2'd1,
    FMT_US      = 2'd2,
    FMT_NONE    = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT    = 2'd0,
    CFG_DECIM     = 2'd1,
    CFG_MIN_RANGE = 2'd2,
    CFG_MAX_RANGE = 2'd3
  } cfg_idx_t;

endpackage

// ===== sv/lidar_point_range_gate.sv =====
// ----------------------------------------------------------------------------
// lidar_point_range_gate: decimating range gate for a lidar point stream
// Keeps every Nth point of a frame, drops bad lines and tags in the
// line-tagged format, gates on squared distance and converts ns time to us.
// ----------------------------------------------------------------------------
// Takes one point beat per clock unless out_tready stalls the pipe, and a kept
// point passes an input register, a register after the three axis squares and
// the ns-to-us reciprocal multiply, and the output register loaded from the
// squared-distance sum and the two bound compares. Each stage holds its beat
// only while the stage after it is full, so a waiting result does not stop new
// input beats from filling empty stages. Dropped points leave no output beat.
// Configuration writes are always taken; the range bounds are squared when
// written, and writes are expected only while no point is in flight.
// ----------------------------------------------------------------------------
module lidar_point_range_gate
  import lprg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_mm, y_mm, z_mm, scan_line, point_tag, reflect, time_raw
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // frame_start
  input  logic                   in_tuser,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_x_mm, out_y_mm, out_z_mm, out_intensity, time_offset_us
  output logic [OUT_TDATA_W-1:0] out_tdata,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int X_LO    = 0;
  localparam int Y_LO    = COORD_WIDTH;
  localparam int Z_LO    = 2 * COORD_WIDTH;
  localparam int LINE_LO = 3 * COORD_WIDTH;
  localparam int TAG_LO  = LINE_LO + LINE_W;
  localparam int REFL_LO = TAG_LO + TAG_W;
  localparam int TIME_LO = REFL_LO + INTEN_W;

  // configuration
  fmt_t                  fmt_r;
  logic [DECIM_W-1:0]    decim_r;
  logic [BOUND_SQ_W-1:0] min_sq_r;
  logic [BOUND_SQ_W-1:0] max_sq_r;
  logic [BOUND_SQ_W-1:0] cfg_sq;

  // decimation
  logic [DECIM_W-1:0]    cnt_r;
  logic [DECIM_W-1:0]    cnt_nxt;
  logic [DECIM_W-1:0]    cnt_base;
  logic [DECIM_W-1:0]    decim_n;
  logic [DECIM_W:0]      cnt_inc;
  logic                  candidate;
  logic                  line_ok;
  logic                  keep_nxt;

  // input fields
  logic [COORD_WIDTH-1:0] in_x, in_y, in_z;
  logic [LINE_W-1:0]      in_line;
  logic [TAG_W-1:0]       in_tag;

  // stage 1: input register
  logic                   s1_valid_r;
  logic                   s1_keep_r;
  logic [COORD_WIDTH-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [INTEN_W-1:0]     s1_refl_r;
  logic [TIME_W-1:0]      s1_time_r;

  // stage 2: squares and time conversion
  logic                   s2_valid_r;
  logic                   s2_keep_r;
  logic [COORD_WIDTH-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic [INTEN_W-1:0]     s2_refl_r;
  logic [TIME_W-1:0]      s2_tus_r;
  logic [TIME_W-1:0]      tus_nxt;
  logic [PROD_W-1:0]      time_prod;
  logic [SQ_W-1:0]        x_sq, y_sq, z_sq;
  logic [SQ_W-1:0]        s2_xsq_r, s2_ysq_r, s2_zsq_r;

  // output register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic [INTEN_W-1:0]     out_refl_r;
  logic [TIME_W-1:0]      out_tus_r;
  logic [CMP_W-1:0]       d2;
  logic                   in_range;

  logic rdy_out, rdy_s2, rdy_s1;
  logic in_beat;

  // ---------------------------------------------------------------- flow
  assign rdy_out   = ~out_valid_r | out_tready;
  assign rdy_s2    = ~s2_valid_r | rdy_out;
  assign rdy_s1    = ~s1_valid_r | rdy_s2;
  assign in_tready = rdy_s1;
  assign in_beat   = in_tvalid & rdy_s1;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  assign cfg_sq = BOUND_SQ_W'(cfg_data) * BOUND_SQ_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_LINE_NS;
      decim_r  <= DECIM_RESET;
      min_sq_r <= MIN_SQ_RESET;
      max_sq_r <= MAX_SQ_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FORMAT:    fmt_r    <= fmt_t'(cfg_data[FMT_W-1:0]);
        CFG_DECIM:     decim_r  <= cfg_data[DECIM_W-1:0];
        CFG_MIN_RANGE: min_sq_r <= cfg_sq;
        CFG_MAX_RANGE: max_sq_r <= cfg_sq;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- decimation
  assign in_x    = in_tdata[X_LO +: COORD_WIDTH];
  assign in_y    = in_tdata[Y_LO +: COORD_WIDTH];
  assign in_z    = in_tdata[Z_LO +: COORD_WIDTH];
  assign in_line = in_tdata[LINE_LO +: LINE_W];
  assign in_tag  = in_tdata[TAG_LO +: TAG_W];

  assign decim_n   = (decim_r == '0) ? DECIM_W'(1) : decim_r;
  assign cnt_base  = in_tuser ? '0 : cnt_r;
  assign candidate = (cnt_base == '0);
  assign cnt_inc   = {1'b0, cnt_base} + (DECIM_W+1)'(1);
  assign cnt_nxt   = (cnt_inc >= {1'b0, decim_n}) ? '0 : cnt_inc[DECIM_W-1:0];

  assign line_ok  = (fmt_r != FMT_LINE_NS) ||
                    ((in_line < LINE_LIMIT) && !in_tag[TAG_DROP_BIT]);
  assign keep_nxt = candidate & line_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_beat) begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy_s1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_keep_r <= keep_nxt;
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s1_z_r    <= in_z;
      s1_refl_r <= in_tdata[REFL_LO +: INTEN_W];
      s1_time_r <= in_tdata[TIME_LO +: TIME_W];
    end
  end

  // ---------------------------------------------------------------- stage 2
  lprg_sq_mag u_sq_x (.coord(s1_x_r), .sq(x_sq));
  lprg_sq_mag u_sq_y (.coord(s1_y_r), .sq(y_sq));
  lprg_sq_mag u_sq_z (.coord(s1_z_r), .sq(z_sq));

  assign time_prod = PROD_W'(s1_time_r) * PROD_W'(DIV1000_MUL);

  always_comb begin
    case (fmt_r)
      FMT_LINE_NS, FMT_NS: tus_nxt = TIME_W'(time_prod >> DIV1000_SHIFT);
      FMT_US:              tus_nxt = s1_time_r;
      default:             tus_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s2 && s1_valid_r) begin
      s2_keep_r <= s1_keep_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_z_r    <= s1_z_r;
      s2_refl_r <= s1_refl_r;
      s2_tus_r  <= tus_nxt;
      s2_xsq_r  <= x_sq;
      s2_ysq_r  <= y_sq;
      s2_zsq_r  <= z_sq;
    end
  end

  // ---------------------------------------------------------------- output
  // sum of three squares cannot overflow D2_W, so no saturation is needed
  assign d2 = CMP_W'(s2_xsq_r) + CMP_W'(s2_ysq_r) + CMP_W'(s2_zsq_r);
  assign in_range = (d2 >= CMP_W'(min_sq_r)) && (d2 <= CMP_W'(max_sq_r));
  assign out_valid_nxt = s2_valid_r & s2_keep_r & in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && out_valid_nxt) begin
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
      out_z_r    <= s2_z_r;
      out_refl_r <= s2_refl_r;
      out_tus_r  <= s2_tus_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_tus_r, out_refl_r, out_z_r, out_y_r, out_x_r});

endmodule

// ===== sv/lprg_sq_mag.sv =====
// ----------------------------------------------------------------------------
// lprg_sq_mag: squared magnitude of one signed coordinate
// Takes the absolute value of a two's complement coordinate and squares it.
// ----------------------------------------------------------------------------
module lprg_sq_mag
  import lprg_pkg::*;
(
  input  logic [COORD_WIDTH-1:0] coord,
  output logic [SQ_W-1:0]        sq
);

  logic [COORD_WIDTH-1:0] mag;

  // most negative value wraps to 2^(w-1), still correct as unsigned
  assign mag = coord[COORD_WIDTH-1] ? (~coord + COORD_WIDTH'(1)) : coord;
  assign sq  = SQ_W'(mag) * SQ_W'(mag);

endmodule
